// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// Every macro takes a label, a clock, an active-low reset, the condition
// pair and a message.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/salru_pkg.sv -----
// ============================================================================
// salru_pkg
// Types, constants and helpers shared by the LRU cache set modules.
// ============================================================================
`default_nettype none

package salru_pkg;

    // Default geometry of the set.
    localparam int NUM_WAYS_DEF = 8;
    localparam int TAG_BITS_DEF = 32;

    // Fixed port widths.
    localparam int REQ_TAG_W = 32;
    localparam int EVT_TAG_W = 32;
    localparam int WAY_OUT_W = 3;
    localparam int OUTCOME_W = 2;

    // Outcome codes of one item.
    localparam logic [OUTCOME_W-1:0] OUT_HIT          = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_MISS_INVALID = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_MISS_FILL    = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_MISS_REPLACE = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

    // Strobes from the sequencer to the line store.
    typedef struct packed {
        logic rd_en;
        logic tag_we;
        logic age_we;
    } mem_cmd_t;

    // Bits needed to index n entries (at least one).
    function automatic int idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/salru_store.sv -----
// ============================================================================
// salru_store
// Tag and age memories of the set, one write port each and a shared
// read address with registered read data.
// ============================================================================
`default_nettype none

module salru_store #(
    parameter int NUM_WAYS = salru_pkg::NUM_WAYS_DEF,
    parameter int TAG_BITS = salru_pkg::TAG_BITS_DEF,
    localparam int WAY_W   = salru_pkg::idx_bits(NUM_WAYS)
) (
    input  wire                      clk,
    input  salru_pkg::mem_cmd_t      mem_cmd,
    input  wire  [WAY_W-1:0]         rd_addr,
    input  wire  [WAY_W-1:0]         wr_addr,
    input  wire  [TAG_BITS-1:0]      wr_tag,
    input  wire  [WAY_W-1:0]         wr_age,
    output logic [TAG_BITS-1:0]      rd_tag,
    output logic [WAY_W-1:0]         rd_age
);

    logic [TAG_BITS-1:0] tag_mem [NUM_WAYS];
    logic [WAY_W-1:0]    age_mem [NUM_WAYS];
    logic [TAG_BITS-1:0] rd_tag_reg;
    logic [WAY_W-1:0]    rd_age_reg;

    // Writes and registered reads; the sequencer never reads and writes one entry at once.
    always_ff @(posedge clk)
    begin
        if (mem_cmd.tag_we)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (mem_cmd.age_we)
        begin
            age_mem[wr_addr] <= wr_age;
        end
        if (mem_cmd.rd_en)
        begin
            rd_tag_reg <= tag_mem[rd_addr];
            rd_age_reg <= age_mem[rd_addr];
        end
    end

    assign rd_tag = rd_tag_reg;
    assign rd_age = rd_age_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/salru_ctrl.sv -----
// ============================================================================
// salru_ctrl
// Sequencer of the set: scans every way, picks the way to use, then sweeps
// the age memory to move that way to the most recently used position.
// ============================================================================
`default_nettype none

module salru_ctrl #(
    parameter int NUM_WAYS = salru_pkg::NUM_WAYS_DEF,
    parameter int TAG_BITS = salru_pkg::TAG_BITS_DEF,
    localparam int WAY_W   = salru_pkg::idx_bits(NUM_WAYS)
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    input  wire  [salru_pkg::REQ_TAG_W-1:0]      req_tag,
    output logic                                 busy,
    output logic                                 done,
    output logic [salru_pkg::OUTCOME_W-1:0]      outcome,
    output logic [salru_pkg::WAY_OUT_W-1:0]      way_used,
    output logic                                 evicted_valid,
    output logic [salru_pkg::EVT_TAG_W-1:0]      evicted_tag,
    output salru_pkg::mem_cmd_t                  mem_cmd,
    output logic [WAY_W-1:0]                     rd_addr,
    output logic [WAY_W-1:0]                     wr_addr,
    output logic [TAG_BITS-1:0]                  wr_tag,
    output logic [WAY_W-1:0]                     wr_age,
    input  wire  [TAG_BITS-1:0]                  rd_tag,
    input  wire  [WAY_W-1:0]                     rd_age
);

    localparam int CNT_W = $clog2(NUM_WAYS + 1);
    localparam int RX_W  = (TAG_BITS > salru_pkg::REQ_TAG_W) ? TAG_BITS : salru_pkg::REQ_TAG_W;
    localparam int EX_W  = (TAG_BITS > salru_pkg::EVT_TAG_W) ? TAG_BITS : salru_pkg::EVT_TAG_W;
    localparam int WX_W  = (WAY_W > salru_pkg::WAY_OUT_W) ? WAY_W : salru_pkg::WAY_OUT_W;
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);

    salru_pkg::state_t state_reg, state_next;

    // Control state.
    logic [NUM_WAYS-1:0] valid_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    addr_reg;
    logic                rd_pend_reg;
    logic                done_reg;
    logic                match_found_reg;
    logic                inval_found_reg;

    // Item payload and scan results.
    logic [WAY_W-1:0]    rd_idx_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [WAY_W-1:0]    match_way_reg;
    logic                match_valid_reg;
    logic [WAY_W-1:0]    match_age_reg;
    logic [WAY_W-1:0]    inval_way_reg;
    logic [WAY_W-1:0]    lru_way_reg;
    logic [TAG_BITS-1:0] lru_tag_reg;
    logic [WAY_W-1:0]    target_reg;
    logic                listed_reg;
    logic [WAY_W-1:0]    pos_reg;
    logic [WAY_W-1:0]    new_age_reg;
    logic [salru_pkg::OUTCOME_W-1:0] outcome_reg;
    logic [salru_pkg::WAY_OUT_W-1:0] way_reg;
    logic                ev_valid_reg;
    logic [salru_pkg::EVT_TAG_W-1:0] ev_tag_reg;

    logic                accept;
    logic                issue;
    logic                sweep_last;
    logic                line_valid;
    logic                line_hit;
    logic [RX_W-1:0]     req_ext;
    logic [TAG_BITS-1:0] tag_in;
    logic [EX_W-1:0]     lru_ext;
    logic [WX_W-1:0]     tgt_ext;
    logic [WAY_W-1:0]    dec_target;
    logic                dec_listed;
    logic [WAY_W-1:0]    dec_pos;
    logic                dec_replace;
    logic [salru_pkg::OUTCOME_W-1:0] dec_outcome;

    // Handshake and sweep bookkeeping.
    assign accept     = (state_reg == salru_pkg::ST_IDLE) && start;
    assign busy       = (state_reg != salru_pkg::ST_IDLE);
    assign issue      = (addr_reg < CNT_W'(NUM_WAYS));
    assign sweep_last = rd_pend_reg && (rd_idx_reg == LAST_WAY);

    // Request tag cut to the stored width.
    assign req_ext = RX_W'(req_tag);
    assign tag_in  = req_ext[TAG_BITS-1:0];

    // An invalid way is treated as holding the empty tag, so it matches only tag zero.
    assign line_valid = valid_reg[rd_idx_reg];
    assign line_hit   = line_valid ? (rd_tag == tag_reg) : (tag_reg == '0);

    // Choice of the way once the scan is complete.
    always_comb
    begin
        dec_replace = 1'b0;
        if (match_found_reg)
        begin
            dec_target  = match_way_reg;
            dec_listed  = match_valid_reg;
            dec_pos     = match_age_reg;
            dec_outcome = match_valid_reg ? salru_pkg::OUT_HIT : salru_pkg::OUT_MISS_INVALID;
        end
        else if (inval_found_reg)
        begin
            dec_target  = inval_way_reg;
            dec_listed  = 1'b0;
            dec_pos     = '0;
            dec_outcome = salru_pkg::OUT_MISS_FILL;
        end
        else
        begin
            dec_target  = lru_way_reg;
            dec_listed  = 1'b1;
            dec_pos     = '0;
            dec_outcome = salru_pkg::OUT_MISS_REPLACE;
            dec_replace = 1'b1;
        end
    end

    assign lru_ext = EX_W'(lru_tag_reg);
    assign tgt_ext = WX_W'(dec_target);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= salru_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and memory strobes.
    always_comb
    begin
        state_next = state_reg;
        mem_cmd    = '0;
        rd_addr    = addr_reg[WAY_W-1:0];
        wr_addr    = rd_idx_reg;
        wr_tag     = tag_reg;
        wr_age     = new_age_reg;
        unique case (state_reg)
            salru_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = salru_pkg::ST_SCAN;
                end
            end
            salru_pkg::ST_SCAN:
            begin
                mem_cmd.rd_en = issue;
                if (sweep_last)
                begin
                    state_next = salru_pkg::ST_DECIDE;
                end
            end
            salru_pkg::ST_DECIDE:
            begin
                // A hit keeps the stored tag; every other outcome stores the
                // request tag, so a validated way holds its tag in memory.
                mem_cmd.tag_we = (dec_outcome != salru_pkg::OUT_HIT);
                wr_addr        = dec_target;
                state_next     = salru_pkg::ST_UPDATE;
            end
            salru_pkg::ST_UPDATE:
            begin
                mem_cmd.rd_en = issue;
                if (rd_pend_reg)
                begin
                    if (rd_idx_reg == target_reg)
                    begin
                        mem_cmd.age_we = 1'b1;
                        wr_age         = new_age_reg;
                    end
                    else if (listed_reg && valid_reg[rd_idx_reg] && (rd_age > pos_reg))
                    begin
                        // Ways younger than the touched one move one step older.
                        mem_cmd.age_we = 1'b1;
                        wr_age         = rd_age - WAY_W'(1);
                    end
                end
                if (sweep_last)
                begin
                    state_next = salru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = salru_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            count_reg       <= '0;
            addr_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            done_reg        <= 1'b0;
            match_found_reg <= 1'b0;
            inval_found_reg <= 1'b0;
        end
        else
        begin
            done_reg    <= (state_reg == salru_pkg::ST_UPDATE) && sweep_last;
            rd_pend_reg <= mem_cmd.rd_en;
            if ((state_reg == salru_pkg::ST_IDLE) || (state_reg == salru_pkg::ST_DECIDE))
            begin
                addr_reg <= '0;
            end
            else if (mem_cmd.rd_en)
            begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
            if (accept)
            begin
                match_found_reg <= 1'b0;
                inval_found_reg <= 1'b0;
            end
            else if ((state_reg == salru_pkg::ST_SCAN) && rd_pend_reg)
            begin
                if (line_hit)
                begin
                    match_found_reg <= 1'b1;
                end
                if (!line_valid)
                begin
                    inval_found_reg <= 1'b1;
                end
            end
            if (state_reg == salru_pkg::ST_DECIDE)
            begin
                valid_reg[dec_target] <= 1'b1;
                if (!dec_listed)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    // Scan results and the result item.
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_addr;
        if (accept)
        begin
            tag_reg     <= tag_in;
            lru_way_reg <= '0;
            lru_tag_reg <= '0;
        end
        else if ((state_reg == salru_pkg::ST_SCAN) && rd_pend_reg)
        begin
            // Keep the lowest matching and lowest invalid way.
            if (line_hit && !match_found_reg)
            begin
                match_way_reg   <= rd_idx_reg;
                match_valid_reg <= line_valid;
                match_age_reg   <= rd_age;
            end
            if (!line_valid && !inval_found_reg)
            begin
                inval_way_reg <= rd_idx_reg;
            end
            if (line_valid && (rd_age == '0))
            begin
                lru_way_reg <= rd_idx_reg;
                lru_tag_reg <= rd_tag;
            end
        end
        if (state_reg == salru_pkg::ST_DECIDE)
        begin
            target_reg   <= dec_target;
            listed_reg   <= dec_listed;
            pos_reg      <= dec_pos;
            new_age_reg  <= dec_listed ? WAY_W'(count_reg - CNT_W'(1)) : WAY_W'(count_reg);
            outcome_reg  <= dec_outcome;
            way_reg      <= tgt_ext[salru_pkg::WAY_OUT_W-1:0];
            ev_valid_reg <= dec_replace;
            ev_tag_reg   <= dec_replace ? lru_ext[salru_pkg::EVT_TAG_W-1:0] : '0;
        end
    end

    assign done          = done_reg;
    assign outcome       = outcome_reg;
    assign way_used      = way_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_tag   = ev_tag_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/set_assoc_lru_cache_set.sv -----
// ============================================================================
// set_assoc_lru_cache_set
// One set of a set-associative cache with true LRU replacement.
// ============================================================================
// Usage:
//   An item (req_tag) is taken on a rising edge where start is high and busy
//   is low. The set reports one result item per request: done is high for one
//   cycle with outcome, way_used, evicted_valid and evicted_tag valid in that
//   cycle. The receiver cannot stall; the result is lost if not captured.
//   Sequence: busy stays high from the accepting edge until done rises, and
//   done rises at the same edge at which busy falls. A new item may be
//   started in the cycle in which done is shown, so the set takes no new
//   item before it has shown the result of the last. Each item makes two
//   passes over the tag/age memory, one entry per cycle with a registered
//   read: a tag scan and an age update sweep, with a decision state between
//   them, and then the idle state that shows the result.
//   Reset clears all valid bits and the valid count at once; no clearing pass
//   runs, and the first item may be started right after reset is released.
// ============================================================================
`default_nettype none

module set_assoc_lru_cache_set #(
    parameter int NUM_WAYS = salru_pkg::NUM_WAYS_DEF,
    parameter int TAG_BITS = salru_pkg::TAG_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    input  wire  [salru_pkg::REQ_TAG_W-1:0]      req_tag,
    output logic                                 busy,
    output logic                                 done,
    output logic [salru_pkg::OUTCOME_W-1:0]      outcome,
    output logic [salru_pkg::WAY_OUT_W-1:0]      way_used,
    output logic                                 evicted_valid,
    output logic [salru_pkg::EVT_TAG_W-1:0]      evicted_tag
);

    localparam int WAY_W = salru_pkg::idx_bits(NUM_WAYS);

    salru_pkg::mem_cmd_t  mem_cmd;
    logic [WAY_W-1:0]     rd_addr;
    logic [WAY_W-1:0]     wr_addr;
    logic [TAG_BITS-1:0]  wr_tag;
    logic [WAY_W-1:0]     wr_age;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [WAY_W-1:0]     rd_age;

    // Sequencer.
    salru_ctrl #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req_tag       (req_tag),
        .busy          (busy),
        .done          (done),
        .outcome       (outcome),
        .way_used      (way_used),
        .evicted_valid (evicted_valid),
        .evicted_tag   (evicted_tag),
        .mem_cmd       (mem_cmd),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .wr_tag        (wr_tag),
        .wr_age        (wr_age),
        .rd_tag        (rd_tag),
        .rd_age        (rd_age)
    );

    // Tag and age memories.
    salru_store #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_store (
        .clk     (clk),
        .mem_cmd (mem_cmd),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_tag  (wr_tag),
        .wr_age  (wr_age),
        .rd_tag  (rd_tag),
        .rd_age  (rd_age)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/salru_chk.sv -----
// ============================================================================
// salru_chk
// Port-level checks of the LRU cache set, bound to the top level.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module salru_chk (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  start,
    input wire                                  busy,
    input wire                                  done,
    input wire [salru_pkg::OUTCOME_W-1:0]       outcome,
    input wire                                  evicted_valid,
    input wire [salru_pkg::EVT_TAG_W-1:0]       evicted_tag
);

    logic item_taken;
    logic is_replace;
    logic no_evict;

    assign item_taken = start && !busy;
    assign is_replace = (outcome == salru_pkg::OUT_MISS_REPLACE);
    assign no_evict   = done && !evicted_valid;

    // An eviction is reported exactly when the least recently used way was replaced.
    `ASSERT_SAME(a_evict_flag, clk, rst_n, done, evicted_valid == is_replace, "bad evict flag")

    // Without an eviction the evicted tag reads zero.
    `ASSERT_SAME(a_evict_tag, clk, rst_n, no_evict, evicted_tag == '0, "evict tag not zero")

    // A taken item makes the block busy in the next cycle.
    `ASSERT_NEXT(a_busy_after, clk, rst_n, item_taken, busy, "busy not raised after an item")

    // The result is shown only once the block is idle again.
    `ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "result shown while busy")

    // A result lasts a single cycle.
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done longer than one cycle")

endmodule

bind set_assoc_lru_cache_set salru_chk u_salru_chk (.*);

`default_nettype wire

// ----- test/set_assoc_lru_cache_set_tb.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_set_tb
// Self-checking testbench for one set of a true-LRU set-associative cache.
// A behavioral copy of the set predicts the outcome, way, and evicted tag of
// every lookup item. Each done strobe is compared against the oldest
// prediction. Directed lookups cover the empty-tag and fill cases first.
// Random phases then run hot working sets, cyclic LRU thrashing, a stretch
// with no idle cycles, and tags that differ by a single bit.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_set_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import salru_pkg::*;

    localparam int WAYS       = NUM_WAYS_DEF;
    localparam int STALL_MAX  = 1000;
    localparam int DRAIN_WAIT = 2 * WAYS + 4;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [WAY_OUT_W-1:0] way;
        logic                 ev_valid;
        logic [EVT_TAG_W-1:0] ev_tag;
    } lookup_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic [REQ_TAG_W-1:0] req_tag;
    logic                 busy;
    logic                 done;
    logic [OUTCOME_W-1:0] outcome;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 evicted_valid;
    logic [EVT_TAG_W-1:0] evicted_tag;

    // Predicted contents of the set.
    logic                 line_valid [WAYS];
    logic [REQ_TAG_W-1:0] line_tag   [WAYS];
    logic [WAY_OUT_W-1:0] age_list   [WAYS];
    int                   age_len;

    lookup_t              pending_lookups [$];
    logic [REQ_TAG_W-1:0] tag_pool [16];
    int                   error_count;
    int                   stall_cycles;
    bit                   idle_enable;

    set_assoc_lru_cache_set dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req_tag       (req_tag),
        .busy          (busy),
        .done          (done),
        .outcome       (outcome),
        .way_used      (way_used),
        .evicted_valid (evicted_valid),
        .evicted_tag   (evicted_tag)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Move a way to the most recently used end of the age list.
    function automatic void touch_way(input int way);
        int kept;
        kept = 0;
        for (int i = 0; i < age_len; i++)
        begin
            if (int'(age_list[i]) != way)
            begin
                age_list[kept] = age_list[i];
                kept++;
            end
        end
        if (kept < WAYS)
        begin
            age_list[kept] = WAY_OUT_W'(way);
            kept++;
        end
        age_len = kept;
    endfunction

    // Look a tag up in the predicted set and update it as the block will.
    function automatic lookup_t predict_lookup(input logic [REQ_TAG_W-1:0] tag);
        lookup_t res;
        int      way;
        way = -1;
        res = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (way < 0 && line_tag[i] == tag)
                way = i;
        end
        if (way >= 0)
        begin
            res.outcome = line_valid[way] ? OUT_HIT : OUT_MISS_INVALID;
        end
        else
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                if (way < 0 && !line_valid[i])
                    way = i;
            end
            if (way >= 0)
            begin
                res.outcome = OUT_MISS_FILL;
            end
            else
            begin
                res.outcome  = OUT_MISS_REPLACE;
                way          = (age_len > 0) ? int'(age_list[0]) : 0;
                res.ev_valid = 1'b1;
                res.ev_tag   = line_tag[way];
            end
            line_tag[way] = tag;
        end
        line_valid[way] = 1'b1;
        touch_way(way);
        res.way = WAY_OUT_W'(way);
        return res;
    endfunction

    // Offer one lookup item and wait until the block takes it.
    task automatic send_lookup(input logic [REQ_TAG_W-1:0] tag);
        lookup_t want;
        start   <= 1'b1;
        req_tag <= tag;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = predict_lookup(tag);
        pending_lookups.insert(pending_lookups.size(), want);
        if (idle_enable && $urandom_range(0, 99) < 11)
        begin
            // Stay idle past the end of the item so the block sits ready.
            start   <= 1'b0;
            req_tag <= $urandom;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            repeat ($urandom_range(0, 3))
                @(posedge clk);
        end
    endtask

    // Hold off the next item until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    // Empty tags on invalid ways, fills up to a full set, then evictions.
    task automatic test_fill_and_evict();
        logic [REQ_TAG_W-1:0] seq [22] = '{
            32'h0000_0005, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hAAAA_AAAA,
            32'h0000_0005, 32'h5555_5555, 32'hDEAD_BEEF, 32'h0000_0000,
            32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
            32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFE, 32'h0000_0001,
            32'h5555_5555, 32'h0000_0000
        };
        foreach (seq[i])
            send_lookup(seq[i]);
        drain_results();
    endtask

    // A working set smaller than the set: mostly hits.
    task automatic test_hot_set(input int count);
        logic [REQ_TAG_W-1:0] tag;
        for (int i = 0; i < 6; i++)
            tag_pool[i] = $urandom;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 10)
                tag = $urandom;
            else
                tag = tag_pool[$urandom_range(0, 5)];
            send_lookup(tag);
        end
        drain_results();
    endtask

    // One more tag than ways, touched in turn: each access evicts the LRU way.
    task automatic test_lru_cycle(input int count);
        logic [REQ_TAG_W-1:0] tag;
        int                   slot;
        slot = 0;
        for (int i = 0; i < WAYS + 1; i++)
            tag_pool[i] = $urandom;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                tag = $urandom;
            end
            else
            begin
                tag  = tag_pool[slot];
                slot = (slot + 1) % (WAYS + 1);
            end
            send_lookup(tag);
        end
        drain_results();
    endtask

    // Back-to-back items over a working set twice the set size.
    task automatic test_back_to_back(input int count);
        logic [REQ_TAG_W-1:0] tag;
        for (int i = 0; i < 16; i++)
            tag_pool[i] = $urandom;
        idle_enable = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 20)
                tag = $urandom;
            else
                tag = tag_pool[$urandom_range(0, 15)];
            send_lookup(tag);
        end
        idle_enable = 1'b1;
        drain_results();
    endtask

    // Tags one bit apart, so every compare bit has to decide the match.
    task automatic test_near_tags(input int count);
        logic [REQ_TAG_W-1:0] base;
        logic [REQ_TAG_W-1:0] tag;
        base        = $urandom;
        tag_pool[0] = base;
        for (int i = 1; i < 10; i++)
            tag_pool[i] = base ^ (32'h1 << $urandom_range(0, 31));
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 15)
                tag = $urandom;
            else
                tag = tag_pool[$urandom_range(0, 9)];
            send_lookup(tag);
        end
        drain_results();
    endtask

    // Compare each result item with the oldest prediction; track progress.
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && ((start && !busy) || done))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("unexpected result: outcome %0d way %0d", outcome, way_used);
                error_count++;
            end
            else
            begin
                want = pending_lookups[0];
                pending_lookups.delete(0);
                if (outcome !== want.outcome)
                begin
                    $error("outcome: expected %0d, got %0d", want.outcome, outcome);
                    error_count++;
                end
                if (way_used !== want.way)
                begin
                    $error("way_used: expected %0d, got %0d", want.way, way_used);
                    error_count++;
                end
                if (evicted_valid !== want.ev_valid)
                begin
                    $error("evicted_valid: expected %0d, got %0d",
                           want.ev_valid, evicted_valid);
                    error_count++;
                end
                if (evicted_tag !== want.ev_tag)
                begin
                    $error("evicted_tag: expected %h, got %h", want.ev_tag, evicted_tag);
                    error_count++;
                end
            end
        end
    end

    // End the run if nothing is accepted for too long.
    initial
    begin
        while (stall_cycles < STALL_MAX)
            @(posedge clk);
        $display("** set_assoc_lru_cache_set: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        req_tag      <= '0;
        error_count  = 0;
        stall_cycles = 0;
        idle_enable  = 1'b1;
        age_len      = 0;
        for (int i = 0; i < WAYS; i++)
        begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            age_list[i]   = '0;
        end
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_evict();
        test_hot_set(350);
        test_lru_cycle(300);
        test_back_to_back(400);
        test_near_tags(300);

        // Let any stray result show up before the verdict.
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (error_count == 0)
            $display("** set_assoc_lru_cache_set: PASSED **");
        else
            $display("** set_assoc_lru_cache_set: FAILED **");
        $finish;
    end

endmodule

// ----- set_assoc_lru_cache_set.f -----
+incdir+hw/rtl
hw/rtl/salru_pkg.sv
hw/rtl/salru_store.sv
hw/rtl/salru_ctrl.sv
hw/rtl/set_assoc_lru_cache_set.sv
hw/rtl/salru_chk.sv
test/set_assoc_lru_cache_set_tb.sv
